// ===== hw/rtl/sur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial upload receiver package
// Types, constants and the CRC-32 byte update shared by the receiver modules.
// ----------------------------------------------------------------------------
package sur_pkg;

  localparam int CHUNK_BYTES = 1024;
  localparam int CHUNK_POS_W = $clog2(CHUNK_BYTES + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int MAGIC_LEN = 6;
  localparam logic [7:0] MAGIC_CHARS [MAGIC_LEN] = '{8'h50, 8'h49, 8'h43, 8'h4D, 8'h44, 8'h3A};

  localparam logic [31:0] CMD_HELO = 32'h4845_4C4F;
  localparam logic [31:0] CMD_RBOO = 32'h5242_4F4F;
  localparam logic [31:0] CMD_FILE = 32'h4649_4C45;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] FIELD_SIZE = 3'd1;
  localparam logic [2:0] FIELD_CRC  = 3'd3;
  localparam logic [2:0] FIELD_LAST = 3'd4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_CMD,
    PH_FIELDS,
    PH_DATA
  } phase_e;

  typedef enum logic [2:0] {
    EV_CONNECTED = 3'd0,
    EV_REBOOT    = 3'd1,
    EV_DATA      = 3'd2,
    EV_ACK       = 3'd3,
    EV_MATCH     = 3'd4,
    EV_MISMATCH  = 3'd5
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [31:0] computed_crc;
    logic [31:0] sent_crc;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = ~crc ^ {24'h0, b};
    for (int j = 0; j < 8; j++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return ~r;
  endfunction

endpackage

// ===== hw/rtl/sur_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial upload receiver parser
// Magic hunt, command decode, header field parsing and payload CRC, one byte
// per cycle while fire_i is high, producing up to two results per byte.
// ----------------------------------------------------------------------------
module sur_parser import sur_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output push_t      push_o
);

  phase_e                 phase_q, phase_d;
  logic [2:0]             magic_idx_q, magic_idx_d;
  logic [31:0]            cmd_q, cmd_d;
  logic [1:0]             cmd_cnt_q, cmd_cnt_d;
  logic [2:0]             field_idx_q, field_idx_d;
  logic [31:0]            acc_q, acc_d;
  logic                   digits_done_q, digits_done_d;
  logic [31:0]            bytes_rem_q, bytes_rem_d;
  logic [31:0]            exp_crc_q, exp_crc_d;
  logic [31:0]            run_crc_q, run_crc_d;
  logic [CHUNK_POS_W-1:0] chunk_pos_q, chunk_pos_d;

  logic                   magic_match, magic_done;
  logic [31:0]            cmd_word;
  logic                   cmd_done, is_comma, is_digit, fields_done;
  logic [31:0]            bytes_rem_dec;
  logic                   data_end;
  logic [31:0]            crc_new;
  logic [CHUNK_POS_W-1:0] chunk_next;

  assign magic_match   = byte_i == MAGIC_CHARS[magic_idx_q];
  assign magic_done    = magic_match && (magic_idx_q == 3'(MAGIC_LEN - 1));
  assign cmd_word      = {cmd_q[23:0], byte_i};
  assign cmd_done      = cmd_cnt_q == 2'd3;
  assign is_comma      = byte_i == CHAR_COMMA;
  assign is_digit      = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign fields_done   = is_comma && (field_idx_q == FIELD_LAST);
  assign bytes_rem_dec = bytes_rem_q - 32'd1;
  assign data_end      = bytes_rem_dec == 32'd0;
  assign crc_new       = crc32_byte(run_crc_q, byte_i);
  assign chunk_next    = chunk_pos_q + CHUNK_POS_W'(1);

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_HUNT: begin
        if (magic_done) phase_d = PH_CMD;
      end
      PH_CMD: begin
        if (cmd_done) phase_d = (cmd_word == CMD_FILE) ? PH_FIELDS : PH_HUNT;
      end
      PH_FIELDS: begin
        if (fields_done) phase_d = (bytes_rem_q == 32'd0) ? PH_HUNT : PH_DATA;
      end
      PH_DATA: begin
        if (data_end) phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_comb begin
    magic_idx_d   = magic_idx_q;
    cmd_d         = cmd_q;
    cmd_cnt_d     = cmd_cnt_q;
    field_idx_d   = field_idx_q;
    acc_d         = acc_q;
    digits_done_d = digits_done_q;
    bytes_rem_d   = bytes_rem_q;
    exp_crc_d     = exp_crc_q;
    run_crc_d     = run_crc_q;
    chunk_pos_d   = chunk_pos_q;
    push_o        = '0;
    case (phase_q)
      PH_HUNT: begin
        magic_idx_d = magic_match ? magic_idx_q + 3'd1 : 3'd0;
        if (magic_done) begin
          magic_idx_d = 3'd0;
          cmd_d       = 32'd0;
          cmd_cnt_d   = 2'd0;
        end
      end
      PH_CMD: begin
        cmd_d     = cmd_word;
        cmd_cnt_d = cmd_cnt_q + 2'd1;
        if (cmd_done) begin
          if (cmd_word == CMD_HELO) begin
            push_o.cnt            = 2'd1;
            push_o.res0.event_res = EV_CONNECTED;
            push_o.res0.last      = 1'b1;
          end else if (cmd_word == CMD_RBOO) begin
            push_o.cnt            = 2'd1;
            push_o.res0.event_res = EV_REBOOT;
            push_o.res0.last      = 1'b1;
          end else if (cmd_word == CMD_FILE) begin
            field_idx_d   = 3'd0;
            acc_d         = 32'd0;
            digits_done_d = 1'b0;
          end
        end
      end
      PH_FIELDS: begin
        if (is_comma) begin
          if (field_idx_q == FIELD_SIZE) bytes_rem_d = acc_q;
          if (field_idx_q == FIELD_CRC) exp_crc_d = acc_q;
          acc_d         = 32'd0;
          digits_done_d = 1'b0;
          field_idx_d   = field_idx_q + 3'd1;
          if (fields_done) begin
            field_idx_d = 3'd0;
            run_crc_d   = 32'd0;
            chunk_pos_d = '0;
            if (bytes_rem_q == 32'd0) begin
              push_o.cnt            = 2'd1;
              push_o.res0.event_res = (exp_crc_q == 32'd0) ? EV_MATCH : EV_MISMATCH;
              push_o.res0.sent_crc  = exp_crc_q;
              push_o.res0.last      = 1'b1;
            end
          end
        end else if (!digits_done_q) begin
          if (is_digit) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + {28'h0, byte_i[3:0]};
          end else begin
            digits_done_d = 1'b1;
          end
        end
      end
      PH_DATA: begin
        run_crc_d                = crc_new;
        bytes_rem_d              = bytes_rem_dec;
        push_o.res0.event_res    = EV_DATA;
        push_o.res0.data_byte    = byte_i;
        push_o.res0.computed_crc = crc_new;
        push_o.res0.sent_crc     = exp_crc_q;
        push_o.res1.computed_crc = crc_new;
        push_o.res1.sent_crc     = exp_crc_q;
        push_o.res1.last         = 1'b1;
        if (data_end) begin
          push_o.cnt            = 2'd2;
          push_o.res1.event_res = (crc_new == exp_crc_q) ? EV_MATCH : EV_MISMATCH;
          chunk_pos_d           = '0;
        end else if (chunk_next >= CHUNK_POS_W'(CHUNK_BYTES)) begin
          push_o.cnt            = 2'd2;
          push_o.res1.event_res = EV_ACK;
          chunk_pos_d           = '0;
        end else begin
          push_o.cnt       = 2'd1;
          push_o.res0.last = 1'b1;
          chunk_pos_d      = chunk_next;
        end
      end
      default: begin
        magic_idx_d = 3'd0;
      end
    endcase
    if (!fire_i) push_o.cnt = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      magic_idx_q   <= 3'd0;
      cmd_q         <= 32'd0;
      cmd_cnt_q     <= 2'd0;
      field_idx_q   <= 3'd0;
      acc_q         <= 32'd0;
      digits_done_q <= 1'b0;
      bytes_rem_q   <= 32'd0;
      exp_crc_q     <= 32'd0;
      run_crc_q     <= 32'd0;
      chunk_pos_q   <= '0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      magic_idx_q   <= magic_idx_d;
      cmd_q         <= cmd_d;
      cmd_cnt_q     <= cmd_cnt_d;
      field_idx_q   <= field_idx_d;
      acc_q         <= acc_d;
      digits_done_q <= digits_done_d;
      bytes_rem_q   <= bytes_rem_d;
      exp_crc_q     <= exp_crc_d;
      run_crc_q     <= run_crc_d;
      chunk_pos_q   <= chunk_pos_d;
    end
  end

endmodule

// ===== hw/rtl/sur_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial upload receiver result queue
// Small register queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module sur_res_fifo import sur_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  valid_o,
  input  logic  pop_i,
  output res_t  res_o
);

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wr_ptr_nx;
  logic                  do_pop;

  assign do_pop    = pop_i && valid_o;
  assign wr_ptr_nx = wr_ptr_q + FIFO_PTR_W'(1);
  assign wr_ptr_d  = wr_ptr_q + FIFO_PTR_W'(push_i.cnt);
  assign rd_ptr_d  = rd_ptr_q + FIFO_PTR_W'(do_pop);
  assign count_d   = count_q + FIFO_CNT_W'(push_i.cnt) - FIFO_CNT_W'(do_pop);
  assign space_o   = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign valid_o   = count_q != '0;
  assign res_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_nx] <= push_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/serial_upload_receiver_crc32.sv =====
`timescale 1ns / 1ps
// Each result passes the input byte register and then the result queue before it is offered.
// One byte per cycle while the queue has space; a byte with two results is handed out as two transfers.
// The four-entry result queue stalls the input once three results are waiting.
// Reset is asynchronous and active low; it returns the block to the magic hunt.
// ----------------------------------------------------------------------------
// Serial upload receiver with CRC-32
// Parses the command stream from a serial link and checks uploaded files.
// ----------------------------------------------------------------------------
module serial_upload_receiver_crc32 import sur_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] data_byte, [39:8] computed_crc, [71:40] sent_crc
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  output logic        m_axis_tlast    // last
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       fire, space;
  push_t      push;
  res_t       res;

  assign fire          = in_valid_q && space;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  sur_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  sur_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid),
    .pop_i   (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.sent_crc, res.computed_crc, res.data_byte};
  assign m_axis_tuser = res.event_res;
  assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
  a_status_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_CONNECTED || m_axis_tuser == EV_REBOOT)
    |-> m_axis_tdata == 72'd0 && m_axis_tlast)
    else $error("connected or reboot result carries payload");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_ACK || m_axis_tuser == EV_MATCH ||
                      m_axis_tuser == EV_MISMATCH)
    |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("ack or verdict result not last or has data byte");

  a_match_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_MATCH |-> m_axis_tdata[39:8] == m_axis_tdata[71:40])
    else $error("match reported with differing CRC values");

  a_mismatch_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == EV_MISMATCH
    |-> m_axis_tdata[39:8] != m_axis_tdata[71:40])
    else $error("mismatch reported with equal CRC values");
`endif

endmodule
